[rtl/life_automaton_torus_macros.svh]
// Assertion macros used by the top level to check the torus engine.
`ifndef LIFE_AUTOMATON_TORUS_MACROS_SVH
`define LIFE_AUTOMATON_TORUS_MACROS_SVH

// Same-cycle implication on the rising clock, quiet while reset is held.
`define LAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on the rising clock, quiet while reset is held.
`define LAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lat_pkg.sv]
// Shared types and constants of the toroidal Life engine.
package lat_pkg;

    localparam int MODE_W   = 2;
    localparam int POS_W    = 6;
    localparam int GEN_W    = 16;
    localparam int SIZE_W   = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    localparam logic [SIZE_W-1:0] ROWS_RESET = 7'd16;
    localparam logic [SIZE_W-1:0] COLS_RESET = 7'd16;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // Control from the top level to the generation engine.
    typedef struct packed {
        logic start;
        logic src_half;
    } t_gen_ctl;

    // Status from the generation engine.
    typedef struct packed {
        logic busy;
        logic done;
        logic same;
    } t_gen_sts;

endpackage

[rtl/lat_chan_if.sv]
// Valid/ready channel interfaces for command items and result items.
interface lat_in_if;
    import lat_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              cell_in;
    logic [GEN_W-1:0]  generations;

    modport source (output valid, output mode, output row, output col, output cell_in,
                    output generations, input ready);
    modport sink   (input valid, input mode, input row, input col, input cell_in,
                    input generations, output ready);
endinterface

interface lat_out_if;
    logic valid;
    logic ready;
    logic cell_out;
    logic run_done;

    modport source (output valid, output cell_out, output run_done, input ready);
    modport sink   (input valid, input cell_out, input run_done, output ready);
endinterface

[rtl/lat_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module lat_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/lat_gen.sv]
// Generation engine: sweeps the source half through a 3x3 window and writes the other half.
module lat_gen #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lat_pkg::t_gen_ctl                    i_ctl,
    input  logic [$clog2(MAX_ROWS+1)-1:0]        i_nr,
    input  logic [$clog2(MAX_COLS+1)-1:0]        i_nc,
    input  logic                                 i_rdata,
    output lat_pkg::t_gen_sts                    o_sts,
    output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)
                  + ((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1):0] o_raddr,
    output logic                                 o_we,
    output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)
                  + ((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1):0] o_waddr,
    output logic                                 o_wdata
);
    import lat_pkg::*;

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int KW  = $clog2(MAX_COLS + 2);

    localparam logic [1:0] G_IDLE  = 2'd0;
    localparam logic [1:0] G_SWEEP = 2'd1;
    localparam logic [1:0] G_DRAIN = 2'd2;

    localparam logic [1:0] SUB_UP  = 2'd0;
    localparam logic [1:0] SUB_MID = 2'd1;
    localparam logic [1:0] SUB_DN  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [RW-1:0] r_row, n_row;
    logic [KW-1:0] r_k, n_k;
    logic [1:0]    r_sub, n_sub;
    logic          r_src;
    logic          r_same;

    // Read-return stage.
    logic          r_v1;
    logic [1:0]    r_sub1;
    logic          r_wr1;
    logic [RW-1:0] r_row1;
    logic [CW-1:0] r_col1;
    logic [1:0]    r_buf;

    // Window and update stage.
    logic [2:0]    r_wl, r_wc, r_wr;
    logic          r_v2;
    logic [RW-1:0] r_row2;
    logic [CW-1:0] r_col2;

    logic [RCW-1:0] nr_m1;
    logic [CCW-1:0] nc_m1;
    logic [KW-1:0]  k_last;
    logic           row_last;
    logic [RW-1:0]  row_up, row_dn, row_sel;
    logic [CW-1:0]  col_sel;
    logic [3:0]     nbr;
    logic           self_bit;
    logic           next_bit;

    always_comb begin
        nr_m1    = i_nr - RCW'(1);
        nc_m1    = i_nc - CCW'(1);
        k_last   = KW'(i_nc) + KW'(1);
        row_last = (RCW'(r_row) == nr_m1);
        row_up   = (r_row == '0) ? RW'(nr_m1) : r_row - RW'(1);
        row_dn   = row_last ? '0 : r_row + RW'(1);
        unique case (r_sub)
            SUB_UP:  row_sel = row_up;
            SUB_MID: row_sel = r_row;
            default: row_sel = row_dn;
        endcase
        // Column walk: left wrap, then every column, then right wrap.
        priority if (r_k == '0) begin
            col_sel = CW'(nc_m1);
        end else if (r_k == k_last) begin
            col_sel = '0;
        end else begin
            col_sel = CW'(r_k - KW'(1));
        end
    end

    assign o_raddr = {r_src, row_sel, col_sel};

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_k     = r_k;
        n_sub   = r_sub;
        unique case (r_state)
            G_IDLE: begin
                if (i_ctl.start) begin
                    n_state = G_SWEEP;
                    n_row   = '0;
                    n_k     = '0;
                    n_sub   = SUB_UP;
                end
            end
            G_SWEEP: begin
                if (r_sub == SUB_DN) begin
                    n_sub = SUB_UP;
                    if (r_k == k_last) begin
                        n_k = '0;
                        if (row_last) begin
                            n_state = G_DRAIN;
                        end else begin
                            n_row = r_row + RW'(1);
                        end
                    end else begin
                        n_k = r_k + KW'(1);
                    end
                end else begin
                    n_sub = r_sub + 2'd1;
                end
            end
            G_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = G_IDLE;
                end
            end
            default: n_state = G_IDLE;
        endcase
    end

    always_comb begin
        nbr = 4'(r_wl[0]) + 4'(r_wl[1]) + 4'(r_wl[2]) + 4'(r_wc[0]) + 4'(r_wc[2])
            + 4'(r_wr[0]) + 4'(r_wr[1]) + 4'(r_wr[2]);
        self_bit = r_wc[1];
        next_bit = (nbr == BIRTH_COUNT) || (self_bit && (nbr == SURVIVE_COUNT));
    end

    assign o_we    = r_v2;
    assign o_waddr = {~r_src, r_row2, r_col2};
    assign o_wdata = next_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_same  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == G_SWEEP);
            r_v2    <= r_v1 && (r_sub1 == SUB_DN) && r_wr1;
            if (r_state == G_IDLE && i_ctl.start) begin
                r_same <= 1'b1;
            end else if (r_v2) begin
                r_same <= r_same && (next_bit == self_bit);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_k   <= n_k;
        r_sub <= n_sub;
        if (r_state == G_IDLE && i_ctl.start) begin
            r_src <= i_ctl.src_half;
        end
        // Tag the read in flight.
        r_sub1 <= r_sub;
        r_wr1  <= (r_k >= KW'(2));
        r_row1 <= r_row;
        r_col1 <= CW'(r_k - KW'(2));
        // Assemble the column and shift it into the window.
        if (r_v1) begin
            unique case (r_sub1)
                SUB_UP:  r_buf[0] <= i_rdata;
                SUB_MID: r_buf[1] <= i_rdata;
                default: begin
                    r_wl <= r_wc;
                    r_wc <= r_wr;
                    r_wr <= {i_rdata, r_buf[1], r_buf[0]};
                end
            endcase
        end
        r_row2 <= r_row1;
        r_col2 <= r_col1;
    end

    assign o_sts.busy = (r_state != G_IDLE);
    assign o_sts.done = (r_state == G_DRAIN) && !r_v1 && !r_v2;
    assign o_sts.same = r_same;
endmodule

[rtl/life_automaton_torus.sv]
// Top level of the toroidal Life engine: command decode, grid memory and result register.
//
//  Channel   Direction  Transfer when         Carries
//  i_in      in         valid & ready         mode, row, col, cell_in, generations
//  o_out     out        valid & ready         cell_out, run_done
//  i_cfg_*   in         i_cfg_we high         rows (index 0), cols (index 1)
//
//  A cell read returns through the registered read port of the grid memory. During a
//  run the single read port of the grid memory feeds three cells per window column,
//  plus a pipeline drain between generations. A run stops early once a generation
//  equals the one before.
//  Reset is synchronous: it clears the half select and loads rows and cols with 16; the
//  grid memory keeps its contents. While a result waits untaken, input ready stays low.
module life_automaton_torus #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lat_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lat_pkg::SIZE_W-1:0]      i_cfg_data,
    lat_in_if.sink                          i_in,
    lat_out_if.source                       o_out
);
    import lat_pkg::*;

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW  = 1 + RW + CW;
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // Control state.
    logic             r_state, n_state;
    logic             r_half, n_half;
    logic             r_kick, n_kick;
    logic             r_rd_pend;
    logic             r_out_valid, n_out_valid;
    logic [SIZE_W-1:0] r_rows, r_cols;

    // Payload.
    logic             r_rd_inrange;
    logic [GEN_W-1:0] r_gens_left, n_gens_left;
    logic             r_cell_out, n_cell_out;
    logic             r_run_done, n_run_done;

    logic [RCW-1:0]   nr;
    logic [CCW-1:0]   nc;
    logic             in_ready;
    logic             accept;
    logic             in_range;
    logic [AW-1:0]    cmd_addr;

    t_gen_ctl         gen_ctl;
    t_gen_sts         gen_sts;
    logic [AW-1:0]    gen_raddr, gen_waddr;
    logic             gen_we, gen_wdata;

    logic             ram_we, ram_wdata, ram_rdata;
    logic [AW-1:0]    ram_waddr, ram_raddr;

    // Clamp the sizes in use: zero acts as one, anything above the maximum as the maximum.
    always_comb begin
        priority if (r_rows == '0) begin
            nr = RCW'(1);
        end else if (32'(r_rows) > MAX_ROWS) begin
            nr = RCW'(MAX_ROWS);
        end else begin
            nr = RCW'(r_rows);
        end
        priority if (r_cols == '0) begin
            nc = CCW'(1);
        end else if (32'(r_cols) > MAX_COLS) begin
            nc = CCW'(MAX_COLS);
        end else begin
            nc = CCW'(r_cols);
        end
    end

    // Take a command only when idle, no read is returning and the result slot frees up.
    assign in_ready   = (r_state == ST_IDLE) && !r_rd_pend && (!r_out_valid || o_out.ready);
    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    assign in_range = (32'(i_in.row) < 32'(nr)) && (32'(i_in.col) < 32'(nc));
    assign cmd_addr = {r_half, RW'(i_in.row), CW'(i_in.col)};

    // Hand the memory to the engine for the whole of a run.
    always_comb begin
        if (r_state == ST_RUN) begin
            ram_we    = gen_we;
            ram_waddr = gen_waddr;
            ram_wdata = gen_wdata;
            ram_raddr = gen_raddr;
        end else begin
            ram_we    = accept && (i_in.mode == MODE_WRITE) && in_range;
            ram_waddr = cmd_addr;
            ram_wdata = i_in.cell_in;
            ram_raddr = cmd_addr;
        end
    end

    lat_ram #(
        .WIDTH (1),
        .DEPTH (2 ** AW)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign gen_ctl.start    = r_kick;
    assign gen_ctl.src_half = r_half;

    lat_gen #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (gen_ctl),
        .i_nr    (nr),
        .i_nc    (nc),
        .i_rdata (ram_rdata),
        .o_sts   (gen_sts),
        .o_raddr (gen_raddr),
        .o_we    (gen_we),
        .o_waddr (gen_waddr),
        .o_wdata (gen_wdata)
    );

    // Command sequencing and the result register.
    always_comb begin
        n_state     = r_state;
        n_half      = r_half;
        n_kick      = 1'b0;
        n_gens_left = r_gens_left;
        n_out_valid = r_out_valid && !o_out.ready;
        n_cell_out  = r_cell_out;
        n_run_done  = r_run_done;

        if (r_rd_pend) begin
            // Read data is back: return zero if the position lay outside the grid.
            n_out_valid = 1'b1;
            n_cell_out  = r_rd_inrange && ram_rdata;
            n_run_done  = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority if (i_in.mode == MODE_READ) begin
                        // Result is presented once the registered memory read returns.
                    end else if (i_in.mode == MODE_RUN && i_in.generations != '0) begin
                        n_state     = ST_RUN;
                        n_kick      = 1'b1;
                        n_gens_left = i_in.generations;
                    end else begin
                        // Write, empty run or unused mode: answer at once.
                        n_out_valid = 1'b1;
                        n_cell_out  = 1'b0;
                        n_run_done  = (i_in.mode == MODE_RUN);
                    end
                end
            end
            ST_RUN: begin
                if (gen_sts.done) begin
                    // The new half now holds the latest generation.
                    n_half = ~r_half;
                    if (r_gens_left == GEN_W'(1) || gen_sts.same) begin
                        n_state     = ST_IDLE;
                        n_out_valid = 1'b1;
                        n_cell_out  = 1'b0;
                        n_run_done  = 1'b1;
                    end else begin
                        n_gens_left = r_gens_left - GEN_W'(1);
                        n_kick      = 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_half      <= 1'b0;
            r_kick      <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_rows      <= ROWS_RESET;
            r_cols      <= COLS_RESET;
        end else begin
            r_state     <= n_state;
            r_half      <= n_half;
            r_kick      <= n_kick;
            r_rd_pend   <= accept && (i_in.mode == MODE_READ);
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ROWS: r_rows <= i_cfg_data;
                    CFG_COLS: r_cols <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_inrange <= in_range;
        r_gens_left  <= n_gens_left;
        r_cell_out   <= n_cell_out;
        r_run_done   <= n_run_done;
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.cell_out = r_cell_out;
    assign o_out.run_done = r_run_done;

    // Checks.
`include "life_automaton_torus_macros.svh"

    `LAT_ASSERT_NEXT(a_read_returns, r_rd_pend, o_out.valid, "read result not presented")
    `LAT_ASSERT_NOW(a_engine_idle, r_state == ST_IDLE, !gen_sts.busy, "engine busy while idle")
    `LAT_ASSERT_NOW(a_no_take_in_run, r_state == ST_RUN, !in_ready, "command taken during run")
    `LAT_ASSERT_NEXT(a_half_hold, !gen_sts.done, r_half == $past(r_half), "half moved without generation")

endmodule
